// ===== src/smtd_pkg.sv =====
// Shared types, codes and sizing for the slot mailbox timer dispatcher.
// No dependencies.
`timescale 1ns / 1ps
package smtd_pkg;

  localparam int SLOTS       = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MB_DEPTH = SLOTS * QUEUE_DEPTH;
  localparam int MB_AW    = (MB_DEPTH > 1) ? $clog2(MB_DEPTH) : 1;

  typedef enum logic [3:0] {
    REQ_ALLOC   = 4'd0,
    REQ_GET     = 4'd1,
    REQ_SET     = 4'd2,
    REQ_KILL    = 4'd3,
    REQ_POST    = 4'd4,
    REQ_SET_TMR = 4'd5,
    REQ_CHG_TMR = 4'd6,
    REQ_CLR_TMR = 4'd7,
    REQ_TICK    = 4'd8
  } req_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_NO_FREE      = 4'd1,
    ST_NOT_IN_SCHED = 4'd2,
    ST_WRONG_SLOT   = 4'd3,
    ST_WRONG_FLAG   = 4'd4,
    ST_WRONG_MSG    = 4'd5,
    ST_QUEUE_FULL   = 4'd6,
    ST_WRONG_PERIOD = 4'd7,
    ST_NO_TIMER     = 4'd8
  } status_t;

  localparam logic [7:0] CODE_NONE  = 8'd0;
  localparam logic [7:0] CODE_IDLE  = 8'd1;
  localparam logic [7:0] CODE_TIMER = 8'd2;
  localparam logic [7:0] CODE_FINAL = 8'd3;

  localparam int FL_ALIVE  = 0;
  localparam int FL_IDLE   = 1;
  localparam int FL_REPEAT = 2;
  localparam int FL_TEN    = 3;
  localparam int FL_IMM    = 4;

  localparam logic [2:0] FSEL_ALIVE = 3'd0;
  localparam logic [2:0] FSEL_MAX   = 3'd4;

  typedef logic [4:0] flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHG,
    S_TRD,
    S_TEVAL,
    S_TEMIT,
    S_STATUS
  } state_t;

  function automatic logic [MB_AW-1:0] mb_addr(logic [SLOT_W-1:0] s, logic [PTR_W-1:0] p);
    return MB_AW'(s) * MB_AW'(QUEUE_DEPTH) + MB_AW'(p);
  endfunction

endpackage

// ===== src/smtd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module smtd_ram #(
  parameter int W = 8,
  parameter int D = 8,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/slot_mailbox_timer_dispatcher.sv =====
// Slot mailbox timer dispatcher: slot table, request decoder and tick walker.
// Depends on smtd_pkg and smtd_ram.
//
// Every request answers with a status word carrying out_last; dispatch words
// precede it. Simple requests give their status on the cycle after start; kill
// and set timer with an immediate fire give two words on consecutive cycles;
// change timer reads then writes the timer memory. A tick walks the slots:
// each is read in S_TRD and, if alive, evaluated in S_TEVAL with any dispatch
// words given in S_TEMIT; the status word follows. Each slot's mailbox head and
// timer entry are read through the single registered read port of each memory.
// Results are strobed on out_valid for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module slot_mailbox_timer_dispatcher import smtd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_req_type,
  input  logic        in_use_current,
  input  logic [7:0]  in_target_slot,
  input  logic [2:0]  in_flag_select,
  input  logic        in_new_flag_value,
  input  logic [7:0]  in_message_code,
  input  logic [31:0] in_period_ms,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [2:0]  out_result_slot,
  output logic        out_is_dispatch,
  output logic [7:0]  out_dispatch_message,
  output logic        out_flag_state,
  output logic        out_last
);

  state_t              state_r, state_nxt;
  flags_t              flags_r [SLOTS];
  flags_t              flags_nxt [SLOTS];
  logic [CNT_W-1:0]    cnt_r [SLOTS];
  logic [CNT_W-1:0]    cnt_nxt [SLOTS];
  logic [PTR_W-1:0]    head_r [SLOTS];
  logic [PTR_W-1:0]    head_nxt [SLOTS];
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [2:0]          mask_r, mask_nxt;
  status_t             st_r, st_nxt;
  logic [SLOT_W-1:0]   rslot_r, rslot_nxt;
  logic [31:0]         now_r, now_nxt;
  logic [31:0]         period_r, period_nxt;
  logic [7:0]          msg_r, msg_nxt;

  logic                o_valid, o_disp, o_flag, o_last;
  status_t             o_status;
  logic [SLOT_W-1:0]   o_slot;
  logic [7:0]          o_msg;
  logic                out_valid_r;
  logic [3:0]          out_status_r;
  logic [2:0]          out_slot_r;
  logic                out_disp_r, out_flag_r, out_last_r;
  logic [7:0]          out_msg_r;

  logic                mb_we;
  logic [MB_AW-1:0]    mb_waddr, mb_raddr;
  logic [7:0]          mb_rdata;
  logic                tm_we;
  logic [SLOT_W-1:0]   tm_waddr, tm_raddr;
  logic [63:0]         tm_wdata, tm_rdata;

  logic [SLOT_W-1:0]   tslot;
  logic                slot_ok;
  status_t             slot_st;
  logic [CNT_W:0]      wsum;
  logic [PTR_W-1:0]    wptr;
  logic                found;
  logic                fire;

  smtd_ram #(.W(8), .D(MB_DEPTH)) u_mbox (
    .clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(in_message_code),
    .raddr(mb_raddr), .rdata(mb_rdata)
  );

  smtd_ram #(.W(64), .D(SLOTS)) u_timer (
    .clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
    .raddr(tm_raddr), .rdata(tm_rdata)
  );

  assign tslot   = in_target_slot[SLOT_W-1:0];
  assign slot_ok = !in_use_current && (in_target_slot < 8'(SLOTS)) && flags_r[tslot][FL_ALIVE];
  assign slot_st = in_use_current ? ST_NOT_IN_SCHED : ST_WRONG_SLOT;
  assign wsum    = (CNT_W + 1)'(head_r[tslot]) + (CNT_W + 1)'(cnt_r[tslot]);
  assign wptr    = (wsum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                   PTR_W'(wsum - (CNT_W + 1)'(QUEUE_DEPTH)) : PTR_W'(wsum);
  assign fire    = flags_r[idx_r][FL_TEN] && ((now_r - tm_rdata[31:0]) >= tm_rdata[63:32]);
  assign busy    = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    flags_nxt  = flags_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    mask_nxt   = mask_r;
    st_nxt     = st_r;
    rslot_nxt  = rslot_r;
    now_nxt    = now_r;
    period_nxt = period_r;
    msg_nxt    = msg_r;
    o_valid    = 1'b0;
    o_status   = ST_OK;
    o_slot     = '0;
    o_disp     = 1'b0;
    o_msg      = CODE_NONE;
    o_flag     = 1'b0;
    o_last     = 1'b0;
    mb_we      = 1'b0;
    mb_waddr   = mb_addr(tslot, wptr);
    mb_raddr   = mb_addr(idx_r, head_r[idx_r]);
    tm_we      = 1'b0;
    tm_waddr   = tslot;
    tm_wdata   = {in_period_ms, in_now_ms};
    tm_raddr   = busy ? idx_r : tslot;
    found      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          o_valid = 1'b1;
          o_last  = 1'b1;
          case (in_req_type)
            REQ_ALLOC: begin
              o_status = ST_NO_FREE;
              for (int i = 0; i < SLOTS; i++) begin
                if (!found && !flags_r[i][FL_ALIVE]) begin
                  found = 1'b1;
                  flags_nxt[i][FL_ALIVE]  = 1'b1;
                  flags_nxt[i][FL_IDLE]   = 1'b1;
                  flags_nxt[i][FL_REPEAT] = 1'b1;
                  flags_nxt[i][FL_TEN]    = 1'b0;
                  cnt_nxt[i]  = '0;
                  head_nxt[i] = '0;
                  o_status = ST_OK;
                  o_slot   = SLOT_W'(i);
                end
              end
            end
            REQ_GET: begin
              if (in_flag_select > FSEL_MAX) begin
                o_status = ST_WRONG_FLAG;
              end else if (!slot_ok) begin
                o_status = slot_st;
              end else begin
                o_flag = flags_r[tslot][in_flag_select];
              end
            end
            REQ_SET: begin
              if (in_flag_select > FSEL_MAX || in_flag_select == FSEL_ALIVE) begin
                o_status = ST_WRONG_FLAG;
              end else if (!slot_ok) begin
                o_status = slot_st;
              end else begin
                flags_nxt[tslot][in_flag_select] = in_new_flag_value;
              end
            end
            REQ_KILL: begin
              if (!slot_ok) begin
                o_status = slot_st;
              end else begin
                o_last    = 1'b0;
                o_disp    = 1'b1;
                o_slot    = tslot;
                o_msg     = CODE_FINAL;
                flags_nxt[tslot][FL_ALIVE] = 1'b0;
                st_nxt    = ST_OK;
                rslot_nxt = '0;
                state_nxt = S_STATUS;
              end
            end
            REQ_POST: begin
              if (in_message_code == CODE_NONE || in_message_code == CODE_IDLE ||
                  in_message_code == CODE_TIMER) begin
                o_status = ST_WRONG_MSG;
              end else if (!slot_ok) begin
                o_status = slot_st;
              end else if (cnt_r[tslot] >= CNT_W'(QUEUE_DEPTH)) begin
                o_status = ST_QUEUE_FULL;
              end else begin
                mb_we = 1'b1;
                cnt_nxt[tslot] = cnt_r[tslot] + 1'b1;
              end
            end
            REQ_SET_TMR: begin
              if (in_period_ms == '0) begin
                o_status = ST_WRONG_PERIOD;
              end else if (!slot_ok) begin
                o_status = slot_st;
              end else begin
                tm_we = 1'b1;
                flags_nxt[tslot][FL_TEN] = 1'b1;
                if (flags_r[tslot][FL_IMM]) begin
                  o_last = 1'b0;
                  o_disp = 1'b1;
                  o_slot = tslot;
                  o_msg  = CODE_TIMER;
                  if (!flags_r[tslot][FL_REPEAT]) begin
                    flags_nxt[tslot][FL_TEN] = 1'b0;
                  end
                  st_nxt    = ST_OK;
                  rslot_nxt = '0;
                  state_nxt = S_STATUS;
                end
              end
            end
            REQ_CHG_TMR: begin
              if (in_period_ms == '0) begin
                o_status = ST_WRONG_PERIOD;
              end else if (!slot_ok) begin
                o_status = slot_st;
              end else if (!flags_r[tslot][FL_TEN]) begin
                o_status = ST_NO_TIMER;
              end else begin
                o_valid    = 1'b0;
                period_nxt = in_period_ms;
                idx_nxt    = tslot;
                state_nxt  = S_CHG;
              end
            end
            REQ_CLR_TMR: begin
              if (!slot_ok) begin
                o_status = slot_st;
              end else if (!flags_r[tslot][FL_TEN]) begin
                o_status = ST_NO_TIMER;
              end else begin
                flags_nxt[tslot][FL_TEN] = 1'b0;
              end
            end
            REQ_TICK: begin
              o_valid   = 1'b0;
              now_nxt   = in_now_ms;
              idx_nxt   = '0;
              state_nxt = S_TRD;
            end
            default: begin
              o_status = ST_OK;
            end
          endcase
        end
      end
      S_CHG: begin
        tm_we     = 1'b1;
        tm_waddr  = idx_r;
        tm_wdata  = {period_r, tm_rdata[31:0]};
        o_valid   = 1'b1;
        o_last    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_TRD: begin
        if (flags_r[idx_r][FL_ALIVE]) begin
          state_nxt = S_TEVAL;
        end else if (idx_r == SLOT_W'(SLOTS - 1)) begin
          st_nxt = ST_OK;
          rslot_nxt = '0;
          state_nxt = S_STATUS;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TEVAL: begin
        mask_nxt = {fire, flags_r[idx_r][FL_IDLE], (cnt_r[idx_r] != '0)};
        msg_nxt  = mb_rdata;
        if (cnt_r[idx_r] != '0) begin
          cnt_nxt[idx_r]  = cnt_r[idx_r] - 1'b1;
          head_nxt[idx_r] = (head_r[idx_r] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                            head_r[idx_r] + 1'b1;
        end
        if (fire) begin
          tm_we    = 1'b1;
          tm_waddr = idx_r;
          tm_wdata = {tm_rdata[63:32], now_r};
          if (!flags_r[idx_r][FL_REPEAT]) begin
            flags_nxt[idx_r][FL_TEN] = 1'b0;
          end
        end
        if (mask_nxt != '0) begin
          state_nxt = S_TEMIT;
        end else if (idx_r == SLOT_W'(SLOTS - 1)) begin
          st_nxt = ST_OK;
          rslot_nxt = '0;
          state_nxt = S_STATUS;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_TEMIT: begin
        o_valid = 1'b1;
        o_disp  = 1'b1;
        o_slot  = idx_r;
        if (mask_r[0]) begin
          o_msg = msg_r;
        end else if (mask_r[1]) begin
          o_msg = CODE_IDLE;
        end else begin
          o_msg = CODE_TIMER;
        end
        mask_nxt = mask_r & (mask_r - 3'd1);
        if (mask_nxt == '0) begin
          if (idx_r == SLOT_W'(SLOTS - 1)) begin
            st_nxt = ST_OK;
            rslot_nxt = '0;
            state_nxt = S_STATUS;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_TRD;
          end
        end
      end
      S_STATUS: begin
        o_valid   = 1'b1;
        o_last    = 1'b1;
        o_status  = st_r;
        o_slot    = rslot_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      mask_r      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        flags_r[i] <= '0;
        cnt_r[i]   <= '0;
        head_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= o_valid;
      idx_r       <= idx_nxt;
      mask_r      <= mask_nxt;
      flags_r     <= flags_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r         <= st_nxt;
    rslot_r      <= rslot_nxt;
    now_r        <= now_nxt;
    period_r     <= period_nxt;
    msg_r        <= msg_nxt;
    out_status_r <= o_status;
    out_slot_r   <= 3'(o_slot);
    out_disp_r   <= o_disp;
    out_msg_r    <= o_msg;
    out_flag_r   <= o_flag;
    out_last_r   <= o_last;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_result_slot      = out_slot_r;
  assign out_is_dispatch      = out_disp_r;
  assign out_dispatch_message = out_msg_r;
  assign out_flag_state       = out_flag_r;
  assign out_last             = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_not_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_is_dispatch)
    else $error("status word flagged as dispatch");
  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request produced nothing");
  a_emit_mask: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEMIT |-> mask_r != '0)
    else $error("dispatch emission with empty mask");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEVAL |-> cnt_r[idx_r] <= CNT_W'(QUEUE_DEPTH))
    else $error("mailbox count overflow");
`endif

endmodule
